// ===== hw/rtl/lsd_pkg.sv =====
package lsd_pkg;

  localparam int unsigned SCORE_W = 16;
  localparam int unsigned TAG_W   = 16;
  localparam int unsigned REC_W   = SCORE_W + TAG_W;
  localparam int unsigned RADIX   = 10;
  localparam int unsigned DIG_W   = 4;

  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic [TAG_W-1:0]   tag;
  } rec_t;

  // Sequencer states, one-hot
  typedef enum logic [6:0] {
    ST_LOAD  = 7'b0000001,
    ST_CLR   = 7'b0000010,
    ST_COUNT = 7'b0000100,
    ST_SCAN  = 7'b0001000,
    ST_MOVE  = 7'b0010000,
    ST_NEXT  = 7'b0100000,
    ST_EMIT  = 7'b1000000
  } state_t;

  // Controls from sequencer to bucket counters
  typedef struct packed {
    logic               clr;
    logic               cnt_en;
    logic               scan_en;
    logic               move_en;
    logic [DIG_W-1:0]   scan_idx;
  } bkt_ctl_t;

  // Quotient of a score by 10^k (k 0..4) by reciprocal multiplication; 0 for k >= 5
  function automatic logic [SCORE_W-1:0] div_pow10(input logic [SCORE_W-1:0] s,
                                                  input logic [2:0] k);
    logic [47:0]        p;
    logic [SCORE_W-1:0] q;
    p = '0;
    q = '0;
    case (k)
      3'd0: q = s;
      3'd1: begin p = 48'(s) * 48'd52429;  q = SCORE_W'(p >> 19); end
      3'd2: begin p = 48'(s) * 48'd83887;  q = SCORE_W'(p >> 23); end
      3'd3: begin p = 48'(s) * 48'd67109;  q = SCORE_W'(p >> 26); end
      3'd4: begin p = 48'(s) * 48'd107375; q = SCORE_W'(p >> 30); end
      default: q = '0;
    endcase
    return q;
  endfunction

  // Decimal digit of a score at place 10^pw (pw 0..4)
  function automatic logic [DIG_W-1:0] dec_digit(input logic [SCORE_W-1:0] s,
                                                 input logic [2:0] pw);
    logic [SCORE_W-1:0] q_lo;
    logic [SCORE_W-1:0] q_hi;
    logic [SCORE_W-1:0] dgt;
    q_lo = div_pow10(s, pw);
    q_hi = div_pow10(s, pw + 3'd1);
    dgt  = q_lo - ((q_hi << 3) + (q_hi << 1));
    return dgt[DIG_W-1:0];
  endfunction

endpackage

// ===== hw/rtl/lsd_if.sv =====
interface lsd_in_if;
  logic                        valid;
  logic                        ready;
  logic [lsd_pkg::SCORE_W-1:0] score;
  logic [lsd_pkg::TAG_W-1:0]   tag;
  logic                        last;
  modport source (output valid, score, tag, last, input ready);
  modport sink   (input valid, score, tag, last, output ready);
endinterface

interface lsd_out_if;
  logic                        valid;
  logic                        ready;
  logic [lsd_pkg::SCORE_W-1:0] out_score;
  logic [lsd_pkg::TAG_W-1:0]   out_tag;
  logic                        out_last;
  logic                        dropped;
  modport source (output valid, out_score, out_tag, out_last, dropped, input ready);
  modport sink   (input valid, out_score, out_tag, out_last, dropped, output ready);
endinterface

// ===== hw/rtl/lsd_ram.sv =====
module lsd_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one entry, register the read
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/lsd_buckets.sv =====
module lsd_buckets #(
  parameter int unsigned CNT_W = 7
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  lsd_pkg::bkt_ctl_t             ctl,
  input  logic [lsd_pkg::DIG_W-1:0]     dig,
  output logic [CNT_W-1:0]              slot
);

  logic [CNT_W-1:0] cnt_r [lsd_pkg::RADIX];
  logic [CNT_W-1:0] run_r;

  assign slot = cnt_r[dig];

  // Count, turn into exclusive prefix sums one bucket a cycle, hand out slots
  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clr) begin
      for (int i = 0; i < lsd_pkg::RADIX; i++) cnt_r[i] <= '0;
      run_r <= '0;
    end else if (ctl.cnt_en || ctl.move_en) begin
      cnt_r[dig] <= cnt_r[dig] + CNT_W'(1);
    end else if (ctl.scan_en) begin
      cnt_r[ctl.scan_idx] <= run_r;
      run_r <= run_r + cnt_r[ctl.scan_idx];
    end
  end

endmodule

// ===== hw/rtl/lsd_decimal_radix_sorter.sv =====
// Load: one item per cycle into the record memory, ready stays high while loading.
// Sort after the item marked last: per decimal digit of the largest score a pass
// of clear, count, prefix scan over the ten buckets, move to the buffer and copy back.
// Emit: from a registered memory read, a new read only once the output register is free.
// Reset (synchronous, rst_n low) empties the block; memory contents stay undefined.
module lsd_decimal_radix_sorter #(
  parameter int unsigned DEPTH      = 64,
  parameter int unsigned MAX_DIGITS = 5
) (
  input  logic         clk,
  input  logic         rst_n,
  lsd_in_if.sink       in_ch,
  lsd_out_if.source    out_ch
);

  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned RD    = 1 << AW;
  localparam int unsigned SCORE_MAX_W = lsd_pkg::SCORE_W;

  lsd_pkg::state_t state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r;      // records held
  logic             ovf_r;
  logic [SCORE_MAX_W-1:0] mx_r;
  logic [2:0]       pw_r;       // digit place
  logic [CNT_W-1:0] idx_r;      // read index
  logic             phase_r;    // 0: move to buffer, 1: copy back
  logic             rv_r;       // read data valid
  logic [CNT_W-1:0] ridx_r;     // index of the data in flight
  logic [lsd_pkg::DIG_W-1:0] scan_r;
  logic             ov_r;       // output register valid
  lsd_pkg::rec_t    orec_r;
  logic             olast_r, odrop_r;

  // Memories
  logic            s_we, b_we;
  logic [AW-1:0]   s_wa, s_ra, b_wa, b_ra;
  lsd_pkg::rec_t   s_wd, s_rd, b_rd;

  lsd_ram #(.WIDTH(lsd_pkg::REC_W), .DEPTH(RD)) u_store (
    .clk(clk), .we(s_we), .waddr(s_wa), .wdata(s_wd), .raddr(s_ra), .rdata(s_rd));
  lsd_ram #(.WIDTH(lsd_pkg::REC_W), .DEPTH(RD)) u_pass (
    .clk(clk), .we(b_we), .waddr(b_wa), .wdata(s_rd), .raddr(b_ra), .rdata(b_rd));

  // Bucket counters
  lsd_pkg::bkt_ctl_t     bctl;
  logic [lsd_pkg::DIG_W-1:0] dig;
  logic [CNT_W-1:0]      slot;

  assign dig = lsd_pkg::dec_digit(s_rd.score, pw_r);

  lsd_buckets #(.CNT_W(CNT_W)) u_bkt (
    .clk(clk), .rst_n(rst_n), .ctl(bctl), .dig(dig), .slot(slot));

  logic in_acc, out_acc, o_free, rd_go, rd_done, more_digits;
  assign in_acc  = in_ch.valid && in_ch.ready;
  assign out_acc = out_ch.valid && out_ch.ready;
  assign o_free  = !ov_r || out_acc;
  assign in_ch.ready = (state_r == lsd_pkg::ST_LOAD);
  assign rd_done = (idx_r == cnt_r);

  // Another pass while the largest score has a digit at or above the current place, up to MAX_DIGITS
  always_comb begin
    case (pw_r)
      3'd0: more_digits = mx_r >= 16'd1;
      3'd1: more_digits = mx_r >= 16'd10;
      3'd2: more_digits = mx_r >= 16'd100;
      3'd3: more_digits = mx_r >= 16'd1000;
      3'd4: more_digits = mx_r >= 16'd10000;
      default: more_digits = 1'b0;
    endcase
    if (32'(pw_r) >= MAX_DIGITS) more_digits = 1'b0;
  end

  // Read issue: in emit only when the output register can take the data
  assign rd_go = !rd_done && o_free && !rv_r;

  always_comb begin
    s_we = 1'b0; s_wa = cnt_r[AW-1:0]; s_wd = '{score: in_ch.score, tag: in_ch.tag};
    b_we = 1'b0; b_wa = slot[AW-1:0];
    s_ra = idx_r[AW-1:0]; b_ra = idx_r[AW-1:0];
    bctl = '{clr: 1'b0, cnt_en: 1'b0, scan_en: 1'b0, move_en: 1'b0, scan_idx: scan_r};
    unique case (state_r)
      lsd_pkg::ST_LOAD: begin
        s_we = in_acc && (cnt_r < CNT_W'(DEPTH));
      end
      lsd_pkg::ST_CLR:   bctl.clr = 1'b1;
      lsd_pkg::ST_COUNT: bctl.cnt_en = rv_r;
      lsd_pkg::ST_SCAN:  bctl.scan_en = 1'b1;
      lsd_pkg::ST_MOVE: begin
        if (!phase_r) begin
          bctl.move_en = rv_r;
          b_we = rv_r;
        end else begin
          s_we = rv_r;
          s_wa = ridx_r[AW-1:0];
          s_wd = b_rd;
        end
      end
      lsd_pkg::ST_NEXT: ;
      lsd_pkg::ST_EMIT: ;
      default: ;
    endcase
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lsd_pkg::ST_LOAD:  if (in_acc && in_ch.last)
                           state_nxt = lsd_pkg::ST_NEXT;
      lsd_pkg::ST_NEXT:  state_nxt = more_digits ? lsd_pkg::ST_CLR : lsd_pkg::ST_EMIT;
      lsd_pkg::ST_CLR:   state_nxt = lsd_pkg::ST_COUNT;
      lsd_pkg::ST_COUNT: if (rd_done && !rv_r) state_nxt = lsd_pkg::ST_SCAN;
      lsd_pkg::ST_SCAN:  if (scan_r == lsd_pkg::DIG_W'(lsd_pkg::RADIX - 1))
                           state_nxt = lsd_pkg::ST_MOVE;
      lsd_pkg::ST_MOVE:  if (rd_done && !rv_r && phase_r) state_nxt = lsd_pkg::ST_NEXT;
      lsd_pkg::ST_EMIT:  if (rd_done && !rv_r && o_free) state_nxt = lsd_pkg::ST_LOAD;
      default:           state_nxt = lsd_pkg::ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lsd_pkg::ST_LOAD;
      cnt_r <= '0; ovf_r <= 1'b0; mx_r <= '0; pw_r <= '0;
      idx_r <= '0; phase_r <= 1'b0; rv_r <= 1'b0; scan_r <= '0; ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        lsd_pkg::ST_LOAD: begin
          idx_r <= '0; pw_r <= '0; rv_r <= 1'b0; phase_r <= 1'b0;
          if (in_acc) begin
            if (cnt_r < CNT_W'(DEPTH)) begin
              cnt_r <= cnt_r + CNT_W'(1);
              if (in_ch.score > mx_r) mx_r <= in_ch.score;
            end else begin
              ovf_r <= 1'b1;
            end
          end
        end
        lsd_pkg::ST_CLR: begin
          idx_r <= '0; scan_r <= '0; phase_r <= 1'b0; rv_r <= 1'b0;
        end
        lsd_pkg::ST_COUNT: begin
          rv_r <= !rd_done;
          if (!rd_done) idx_r <= idx_r + CNT_W'(1);
          if (rd_done && !rv_r) idx_r <= '0;
        end
        lsd_pkg::ST_SCAN: scan_r <= scan_r + lsd_pkg::DIG_W'(1);
        lsd_pkg::ST_MOVE: begin
          rv_r <= !rd_done;
          ridx_r <= idx_r;
          if (!rd_done) idx_r <= idx_r + CNT_W'(1);
          if (rd_done && !rv_r) begin
            idx_r <= '0;
            if (!phase_r) phase_r <= 1'b1;
            else pw_r <= pw_r + 3'd1;
          end
        end
        lsd_pkg::ST_NEXT: begin
          idx_r <= '0; rv_r <= 1'b0; phase_r <= 1'b0;
        end
        lsd_pkg::ST_EMIT: begin
          // One read in flight at most; result goes to the output register
          if (rv_r) begin
            ov_r <= 1'b1;
            rv_r <= 1'b0;
            orec_r <= s_rd;
            olast_r <= (idx_r == cnt_r);
            odrop_r <= (idx_r == cnt_r) && ovf_r;
          end else begin
            if (out_acc) ov_r <= 1'b0;
            if (rd_go) begin
              rv_r <= 1'b1;
              idx_r <= idx_r + CNT_W'(1);
            end
          end
          if (rd_done && !rv_r && o_free) begin
            cnt_r <= '0; ovf_r <= 1'b0; mx_r <= '0; idx_r <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_ch.valid     = ov_r;
  assign out_ch.out_score = orec_r.score;
  assign out_ch.out_tag   = orec_r.tag;
  assign out_ch.out_last  = olast_r;
  assign out_ch.dropped   = odrop_r;

  // Input is taken only while loading
  a_in_load: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> state_r == lsd_pkg::ST_LOAD) else $error("item accepted outside load");
  // Count never exceeds capacity
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH)) else $error("record count over capacity");
  // Dropped shows only on the final item
  a_drop: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && odrop_r |-> olast_r) else $error("dropped without last");
  // Leaving emit clears the store state
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == lsd_pkg::ST_EMIT && state_nxt == lsd_pkg::ST_LOAD |=> cnt_r == '0)
    else $error("store not emptied");

endmodule

// ===== tb/sv/lsd_sort_checker.sv =====
`timescale 1ns / 100ps

module lsd_sort_checker #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  lsd_in_if           in_mon,
  lsd_out_if          out_mon,
  output int unsigned err_count,
  output int unsigned pending
);
  localparam int unsigned SCORE_W = lsd_pkg::SCORE_W;
  localparam int unsigned TAG_W   = lsd_pkg::TAG_W;

  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic [TAG_W-1:0]   tag;
    logic               last;
    logic               dropped;
  } sorted_rec_t;

  lsd_pkg::rec_t held [CAPACITY];
  int unsigned   held_cnt;
  logic          lost_any;
  sorted_rec_t   sorted_q [$];

  // Stable ascending sort of the held records, then queue them as expected output
  task automatic queue_sorted_run();
    lsd_pkg::rec_t key;
    int            j;
    sorted_rec_t   r;
    for (int i = 1; i < held_cnt; i++) begin
      key = held[i];
      j = i;
      while (j > 0 && held[j-1].score > key.score) begin
        held[j] = held[j-1];
        j--;
      end
      held[j] = key;
    end
    for (int i = 0; i < held_cnt; i++) begin
      r.score   = held[i].score;
      r.tag     = held[i].tag;
      r.last    = (i + 1 == held_cnt);
      r.dropped = r.last && lost_any;
      sorted_q.push_back(r);
    end
  endtask

  always @(posedge clk) begin
    sorted_rec_t e;
    if (!rst_n) begin
      held_cnt  = 0;
      lost_any  = 1'b0;
      err_count <= 0;
      pending   <= 0;
      sorted_q.delete();
    end else begin
      // Compare an accepted result with the oldest expectation
      if (out_mon.valid && out_mon.ready) begin
        if (sorted_q.size() == 0) begin
          $error("unexpected result: score %0d tag %0d", out_mon.out_score, out_mon.out_tag);
          err_count <= err_count + 1;
        end else begin
          e = sorted_q.pop_front();
          if (out_mon.out_score !== e.score || out_mon.out_tag !== e.tag ||
              out_mon.out_last !== e.last || out_mon.dropped !== e.dropped)
            err_count <= err_count + 1;
          if (out_mon.out_score !== e.score)
            $error("out_score: expected %0d, actual %0d", e.score, out_mon.out_score);
          if (out_mon.out_tag !== e.tag)
            $error("out_tag: expected %0d, actual %0d", e.tag, out_mon.out_tag);
          if (out_mon.out_last !== e.last)
            $error("out_last: expected %0d, actual %0d", e.last, out_mon.out_last);
          if (out_mon.dropped !== e.dropped)
            $error("dropped: expected %0d, actual %0d", e.dropped, out_mon.dropped);
        end
      end
      // Load an accepted item, or drop it when the store is full
      if (in_mon.valid && in_mon.ready) begin
        if (held_cnt < CAPACITY) begin
          held[held_cnt].score = in_mon.score;
          held[held_cnt].tag   = in_mon.tag;
          held_cnt = held_cnt + 1;
        end else begin
          lost_any = 1'b1;
        end
        if (in_mon.last) begin
          queue_sorted_run();
          held_cnt = 0;
          lost_any = 1'b0;
        end
      end
      pending <= sorted_q.size();
    end
  end
endmodule

// ===== tb/sv/tb_lsd_decimal_radix_sorter.sv =====
`timescale 1ns / 100ps

module tb_lsd_decimal_radix_sorter;
  localparam int unsigned SCORE_W     = lsd_pkg::SCORE_W;
  localparam int unsigned TAG_W       = lsd_pkg::TAG_W;
  localparam int unsigned CAPACITY    = 64;
  localparam int unsigned CYCLE_LIMIT = 600000;

  logic        clk = 1'b0;
  logic        rst_n;
  int unsigned err_count;
  int unsigned pending;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned items_sent;
  int unsigned cycles = 0;

  lsd_in_if  in_ch ();
  lsd_out_if out_ch ();

  lsd_decimal_radix_sorter #(.DEPTH(CAPACITY), .MAX_DIGITS(5)) dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch)
  );

  lsd_sort_checker #(.CAPACITY(CAPACITY)) chk (
    .clk(clk), .rst_n(rst_n), .in_mon(in_ch), .out_mon(out_ch),
    .err_count(err_count), .pending(pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Receiver stalls at random
  always @(posedge clk) begin
    if (!rst_n) out_ch.ready <= 1'b0;
    else        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Score with a random number of decimal digits
  function automatic logic [SCORE_W-1:0] pick_score();
    int unsigned d;
    d = $urandom_range(6);
    case (d)
      0: return '0;
      1: return SCORE_W'($urandom_range(9));
      2: return SCORE_W'($urandom_range(99, 10));
      3: return SCORE_W'($urandom_range(999, 100));
      4: return SCORE_W'($urandom_range(9999, 1000));
      default: return SCORE_W'($urandom_range(65535, 10000));
    endcase
  endfunction

  // Present one item and hold it until accepted
  task automatic send_item(input logic [SCORE_W-1:0] s, input logic [TAG_W-1:0] t,
                           input logic l);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.score <= s;
    in_ch.tag   <= t;
    in_ch.last  <= l;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  // One set of n records; mode 0 random, 1 all zero scores, 2 few distinct scores
  task automatic send_set(input int unsigned n, input int unsigned mode);
    logic [SCORE_W-1:0] s;
    for (int unsigned i = 0; i < n; i++) begin
      case (mode)
        1:       s = '0;
        2:       s = SCORE_W'($urandom_range(3) * 1001);
        default: s = pick_score();
      endcase
      send_item(s, TAG_W'($urandom_range(65535)), i + 1 == n);
    end
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    rst_n          <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.score    <= '0;
    in_ch.tag      <= '0;
    in_ch.last     <= 1'b0;
    items_sent     = 0;
    send_idle_pct  = 8;
    recv_stall_pct = 45;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: single record, field extremes, all zero scores, ties
    send_item('0, '0, 1'b1);
    send_item(16'hFFFF, 16'hFFFF, 1'b1);
    send_item(16'd65535, 16'd1, 1'b0);
    send_item(16'd0, 16'hFFFF, 1'b0);
    send_item(16'd10, 16'd2, 1'b0);
    send_item(16'd9, 16'd3, 1'b1);
    send_set(5, 1);
    send_item(16'd500, 16'd7, 1'b0);
    send_item(16'd5, 16'd8, 1'b0);
    send_item(16'd500, 16'd9, 1'b0);
    send_item(16'd5, 16'd10, 1'b1);
    // Directed: exactly full store, then a set that overflows it
    send_set(CAPACITY, 0);
    send_set(CAPACITY + 2, 0);
    // Hold off until the sorter has emitted everything
    drain();

    // Random sets, mostly small
    while (items_sent < 255) begin
      if (items_sent > 210)      begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      else if (items_sent > 110) begin send_idle_pct = 45; recv_stall_pct = 8;  end
      case ($urandom_range(19))
        0:       send_set(CAPACITY, 0);
        1:       send_set(CAPACITY + $urandom_range(4, 1), 0);
        2:       send_set($urandom_range(8, 1), 1);
        3, 4:    send_set($urandom_range(10, 2), 2);
        default: send_set($urandom_range(10, 1), 0);
      endcase
    end

    drain();
    repeat (50) @(posedge clk);
    if (err_count == 0) $display("TB_OK");
    else                $display("TB_ERROR");
    $finish;
  end
endmodule
